FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is clocked on clk_i and
// is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every edge.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Whenever ante holds, cons holds at the same edge.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Whenever ante holds, cons holds at the next edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/stree_pkg.sv
package stree_pkg;

  localparam int unsigned LEAVES = 256;
  localparam int unsigned LeafW  = $clog2(LEAVES);
  localparam int unsigned NodeW  = LeafW + 1;
  localparam int unsigned NODES  = 2 * LEAVES;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned DataW  = 32;

  typedef logic [NodeW-1:0] node_addr_t;
  // One extra bit: the left bound may step one past the last node.
  typedef logic [NodeW:0]   node_walk_t;
  typedef logic [LeafW-1:0] build_idx_t;
  typedef logic [DataW-1:0] word_t;

  typedef enum logic [CmdW-1:0] {
    CMD_WRITE = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_QUERY = 2'd2
  } command_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BUILD,
    ST_QUERY
  } state_e;

  typedef struct packed {
    logic clear_step;
    logic leaf_write;
    logic build_start;
    logic build_issue;
    logic build_drain;
    logic query_start;
    logic query_step;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic build_k_one;
    logic build_k_zero;
    logic build_wr_pend;
    logic query_busy;
    logic query_pend;
  } dp_status_t;

  // Node address of a leaf; the index wraps modulo the number of leaves.
  function automatic node_addr_t leaf_addr(logic [IdxW-1:0] idx);
    node_addr_t r;
    r = node_addr_t'(LEAVES) | (node_addr_t'(idx) & node_addr_t'(LEAVES - 1));
    return r;
  endfunction

endpackage

FILE: rtl/stree_cmd_if.sv
interface stree_cmd_if;
  logic                                valid;
  logic                                ready;
  logic        [stree_pkg::CmdW-1:0]   command;
  logic        [stree_pkg::IdxW-1:0]   left_index;
  logic        [stree_pkg::IdxW-1:0]   right_index;
  logic signed [stree_pkg::DataW-1:0]  value;

  modport source (output valid, command, left_index, right_index, value, input ready);
  modport sink   (input valid, command, left_index, right_index, value, output ready);
endinterface

FILE: rtl/stree_sum_if.sv
interface stree_sum_if;
  logic                               valid;
  logic                               ready;
  logic signed [stree_pkg::DataW-1:0] range_sum;

  modport source (output valid, range_sum, input ready);
  modport sink   (input valid, range_sum, output ready);
endinterface

FILE: rtl/stree_ram.sv
module stree_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr0_i,
  input  logic [$clog2(Depth)-1:0] raddr1_i,
  output logic [Width-1:0]         rdata0_o,
  output logic [Width-1:0]         rdata1_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

FILE: rtl/stree_dp.sv
`include "assert_macros.svh"

module stree_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  stree_pkg::dp_cmd_t                cmd_i,
  output stree_pkg::dp_status_t             status_o,
  input  logic        [stree_pkg::IdxW-1:0]  left_index_i,
  input  logic        [stree_pkg::IdxW-1:0]  right_index_i,
  input  logic signed [stree_pkg::DataW-1:0] value_i,
  output logic signed [stree_pkg::DataW-1:0] range_sum_o
);

  import stree_pkg::*;

  node_addr_t clr_q, clr_d;
  logic       wr_pend_q, wr_pend_d;
  logic       pend0_q, pend0_d, pend1_q, pend1_d;
  build_idx_t k_q, k_d;
  build_idx_t wr_node_q, wr_node_d;
  node_walk_t lo_q, lo_d, hi_q, hi_d;
  word_t      acc_q, acc_d;
  word_t      out_q, out_d;

  logic       ram_we;
  node_addr_t ram_waddr, ram_raddr0, ram_raddr1;
  word_t      ram_wdata, ram_rdata0, ram_rdata1;
  logic       lo_le_hi;

  stree_ram #(
    .Width(DataW),
    .Depth(NODES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr0_i(ram_raddr0),
    .raddr1_i(ram_raddr1),
    .rdata0_o(ram_rdata0),
    .rdata1_o(ram_rdata1)
  );

  assign lo_le_hi = (lo_q <= hi_q);

  always_comb begin
    clr_d     = clr_q;
    wr_pend_d = wr_pend_q;
    pend0_d   = pend0_q;
    pend1_d   = pend1_q;
    k_d       = k_q;
    wr_node_d = wr_node_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    acc_d     = acc_q;
    out_d     = out_q;

    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = '0;

    if (cmd_i.build_issue || cmd_i.build_start) begin
      ram_raddr0 = {k_q, 1'b0};
      ram_raddr1 = {k_q, 1'b1};
    end else begin
      ram_raddr0 = lo_q[NodeW-1:0];
      ram_raddr1 = hi_q[NodeW-1:0];
    end

    if (cmd_i.clear_step) begin
      ram_we = 1'b1;
      clr_d  = clr_q + node_addr_t'(1);
    end

    if (cmd_i.leaf_write) begin
      ram_we    = 1'b1;
      ram_waddr = leaf_addr(left_index_i);
      ram_wdata = $unsigned(value_i);
    end

    if (cmd_i.build_start) begin
      k_d       = build_idx_t'(LEAVES - 1);
      wr_pend_d = 1'b0;
    end

    // A pending write stores the sum of the two children read last cycle.
    if ((cmd_i.build_issue || cmd_i.build_drain) && wr_pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = {1'b0, wr_node_q};
      ram_wdata = ram_rdata0 + ram_rdata1;
    end

    if (cmd_i.build_issue) begin
      wr_pend_d = 1'b1;
      wr_node_d = k_q;
      k_d       = k_q - build_idx_t'(1);
    end else if (cmd_i.build_drain) begin
      wr_pend_d = 1'b0;
    end

    if (cmd_i.query_start) begin
      lo_d    = node_walk_t'(leaf_addr(left_index_i));
      hi_d    = node_walk_t'(leaf_addr(right_index_i));
      acc_d   = '0;
      pend0_d = 1'b0;
      pend1_d = 1'b0;
    end

    if (cmd_i.query_step) begin
      acc_d = acc_q + (pend0_q ? ram_rdata0 : word_t'(0))
                    + (pend1_q ? ram_rdata1 : word_t'(0));
      if (lo_le_hi) begin
        pend0_d = lo_q[0];
        pend1_d = !hi_q[0];
        lo_d    = (lo_q + node_walk_t'(lo_q[0])) >> 1;
        hi_d    = (hi_q - node_walk_t'(!hi_q[0])) >> 1;
      end else begin
        pend0_d = 1'b0;
        pend1_d = 1'b0;
      end
    end

    if (cmd_i.publish) begin
      out_d = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      wr_pend_q <= 1'b0;
      pend0_q   <= 1'b0;
      pend1_q   <= 1'b0;
    end else begin
      clr_q     <= clr_d;
      wr_pend_q <= wr_pend_d;
      pend0_q   <= pend0_d;
      pend1_q   <= pend1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    wr_node_q <= wr_node_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    acc_q     <= acc_d;
    out_q     <= out_d;
  end

  assign status_o.clear_last    = (clr_q == node_addr_t'(NODES - 1));
  assign status_o.build_k_one   = (k_q == build_idx_t'(1));
  assign status_o.build_k_zero  = (k_q == build_idx_t'(0));
  assign status_o.build_wr_pend = wr_pend_q;
  assign status_o.query_busy    = lo_le_hi;
  assign status_o.query_pend    = pend0_q | pend1_q;
  assign range_sum_o            = $signed(out_q);

  // A node must never be read in the cycle in which it is being rewritten.
  `ASSERT_ALWAYS(a_no_rw_overlap,
    !(ram_we && (cmd_i.build_issue || cmd_i.query_step) &&
      ((ram_waddr == ram_raddr0) || (ram_waddr == ram_raddr1))),
    "stree_dp: node read while it is written")

endmodule

FILE: rtl/stree_ctrl.sv
`include "assert_macros.svh"

module stree_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [stree_pkg::CmdW-1:0]   in_command_i,
  output logic                         in_ready_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output stree_pkg::dp_cmd_t           cmd_o,
  input  stree_pkg::dp_status_t        status_i
);

  import stree_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (command_e'(in_command_i))
            CMD_WRITE: begin
              cmd_o.leaf_write = 1'b1;
            end
            CMD_BUILD: begin
              cmd_o.build_start = 1'b1;
              state_d           = ST_BUILD;
            end
            CMD_QUERY: begin
              cmd_o.query_start = 1'b1;
              state_d           = ST_QUERY;
            end
            default: begin
            end
          endcase
        end
      end
      ST_BUILD: begin
        if (status_i.build_k_zero) begin
          cmd_o.build_drain = 1'b1;
          state_d           = ST_IDLE;
        end else if (status_i.build_k_one && status_i.build_wr_pend) begin
          // The root reads node 2, so node 2 has to land first.
          cmd_o.build_drain = 1'b1;
        end else begin
          cmd_o.build_issue = 1'b1;
        end
      end
      ST_QUERY: begin
        if (!status_i.query_busy && !status_i.query_pend) begin
          if (!out_valid_q || out_ready_i) begin
            cmd_o.publish = 1'b1;
            out_valid_d   = 1'b1;
            state_d       = ST_IDLE;
          end
        end else begin
          cmd_o.query_step = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `ASSERT_IMPLIES(a_result_from_query, $rose(out_valid_q),
    $past(state_q) == ST_QUERY, "stree_ctrl: result raised outside a query")
  `ASSERT_NEXT(a_clear_exit, state_q == ST_CLEAR,
    (state_q == ST_CLEAR) || (state_q == ST_IDLE), "stree_ctrl: clear pass cut short")

endmodule

FILE: rtl/segment_tree_range_sum.sv
// Range-sum engine over a bottom-up segment tree of LEAVES signed 32-bit
// leaves (256 by default), kept as 2*LEAVES node sums in one two-read-port
// RAM. Each command beat does one of three things. A write puts a value at a
// leaf in the cycle the beat is taken and touches no internal node. A build
// recomputes every internal node from the top leaf pair down to the root,
// one node per cycle, as the two children of a node come out of the RAM's
// two read ports together, with a drain step before the root so that
// node 2 is written before it is read. A query walks both bounds upward one
// tree level per cycle, reading at most two nodes per level through the
// same two ports, and gives one result beat once the walk is done and the
// output register is free; an empty range returns zero. Queries see internal
// nodes as the last build left them, so leaf writes made since then show
// only where a leaf is read directly. Sums wrap modulo 2^32, and indices are
// taken modulo LEAVES. After reset the block clears all 2*LEAVES nodes, one
// per cycle, and takes no command beat until that pass is done. Commands are
// handled one at a time; a finished result waits in an output register, so
// the next command may be taken while the previous result is still unread.
// Command code 3 is accepted and ignored.

module segment_tree_range_sum (
  input  logic clk_i,
  input  logic rst_ni,
  stree_cmd_if.sink   cmd_i,
  stree_sum_if.source sum_o
);

  import stree_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // The controller sequences clear, build and query; the datapath owns the
  // node store, the walk registers and the result register.
  stree_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_command_i(cmd_i.command),
    .in_ready_o  (cmd_i.ready),
    .out_valid_o (sum_o.valid),
    .out_ready_i (sum_o.ready),
    .cmd_o       (dp_cmd),
    .status_i    (dp_status)
  );

  stree_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .status_o     (dp_status),
    .left_index_i (cmd_i.left_index),
    .right_index_i(cmd_i.right_index),
    .value_i      (cmd_i.value),
    .range_sum_o  (sum_o.range_sum)
  );

endmodule
